// ===== rtl/oqkr_pkg.sv =====
// Shared constants and codes for the ordered queue with keyed remove.
package oqkr_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int REQ_W    = 3;
    localparam int IN_VAL_W = 32;
    localparam int OUT_W    = 32;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

// ===== rtl/ordered_queue_with_keyed_remove_core.sv =====
// Ordered queue with keyed remove: one entry memory and a scanning sequencer.
// Push, full, empty-pop and unused codes: busy stays low and the registered
// result strobe rises at the accepting edge. Pop, insert, remove and lookup
// scan one entry per cycle; the result strobe rises in the same cycle that
// busy falls. Reset clears the count and control state, not the entry memory.
// The receiver cannot stall.
module ordered_queue_with_keyed_remove_core #(
    parameter int DEPTH       = oqkr_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = oqkr_pkg::VALUE_WIDTH_DEF,
    parameter int CW          = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [oqkr_pkg::REQ_W-1:0]    i_req_type,
    input  logic [oqkr_pkg::IN_VAL_W-1:0] i_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    output logic                          o_done,
    output logic [oqkr_pkg::STATUS_W-1:0] o_status,
    output logic [oqkr_pkg::OUT_W-1:0]    o_out_value,
    output logic [CW-1:0]                 o_entry_count
);
    import oqkr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;

    typedef logic [VALUE_WIDTH-1:0] t_val;

    t_val r_mem [DEPTH];
    t_val r_rd_data;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic                r_dv, n_dv;
    logic [AW-1:0]       r_didx, n_didx;
    logic                r_hit, n_hit;
    logic [REQ_W-1:0]    r_op, n_op;
    t_val                r_val, n_val;
    t_val                r_carry, n_carry;
    t_val                r_res, n_res;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_done, n_done;
    logic                r_signed;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_val          mem_wdata;
    t_val          in_val;
    t_val          flip;
    logic          lt;
    logic          match;

    assign in_val = VALUE_WIDTH'(i_value);
    assign flip   = t_val'(r_signed) << (VALUE_WIDTH - 1);
    assign lt     = (r_rd_data ^ flip) < (r_val ^ flip);
    assign match  = (r_op == REQ_POP) ? (r_didx == '0) : (r_rd_data == r_val);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_dv      = 1'b0;
        n_didx    = r_didx;
        n_hit     = r_hit;
        n_op      = r_op;
        n_val     = r_val;
        n_carry   = r_carry;
        n_res     = r_res;
        n_status  = r_status;
        n_done    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = r_val;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res    = '0;
                    n_status = ST_OK;
                    n_op     = i_req_type;
                    n_val    = in_val;
                    n_ptr    = '0;
                    n_hit    = 1'b0;
                    case (i_req_type)
                        REQ_PUSH: begin
                            n_done = 1'b1;
                            if (r_count >= CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = in_val;
                                n_count   = CW'(r_count + 1'b1);
                            end
                        end
                        REQ_POP: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        REQ_INSERT: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        REQ_REMOVE, REQ_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Reads run one entry ahead of the data being processed, so a
                // write during the scan targets an entry that has already been read.
                if (r_ptr < r_count) begin
                    n_ptr  = CW'(r_ptr + 1'b1);
                    n_dv   = 1'b1;
                    n_didx = r_ptr[AW-1:0];
                end
                if (r_dv) begin
                    case (r_op)
                        REQ_INSERT: begin
                            if (!r_hit && lt) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_didx;
                                mem_wdata = r_val;
                                n_hit     = 1'b1;
                                n_carry   = r_rd_data;
                            end else if (r_hit) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_didx;
                                mem_wdata = r_carry;
                                n_carry   = r_rd_data;
                            end
                        end
                        REQ_POP, REQ_REMOVE: begin
                            if (!r_hit && match) begin
                                n_hit = 1'b1;
                                n_res = r_rd_data;
                            end else if (r_hit) begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(r_didx - 1'b1);
                                mem_wdata = r_rd_data;
                            end
                        end
                        default: begin
                            if (!r_hit && match) begin
                                n_hit = 1'b1;
                                n_res = r_rd_data;
                            end
                        end
                    endcase
                end else if (r_ptr >= r_count) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    case (r_op)
                        REQ_INSERT: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            mem_wdata = r_hit ? r_carry : r_val;
                            n_count   = CW'(r_count + 1'b1);
                        end
                        REQ_POP, REQ_REMOVE: begin
                            if (r_hit) begin
                                n_count = CW'(r_count - 1'b1);
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (!r_hit) begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_done   <= 1'b0;
            r_signed <= 1'b1;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_signed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_didx   <= n_didx;
        r_hit    <= n_hit;
        r_op     <= n_op;
        r_val    <= n_val;
        r_carry  <= n_carry;
        r_res    <= n_res;
        r_status <= n_status;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_out_value   = OUT_W'(r_res);
    assign o_entry_count = r_count;

endmodule

// ===== rtl/oqkr_checker.sv =====
// Port-level checker for the ordered queue core, with its bind statement.
module oqkr_checker #(
    parameter int DEPTH = oqkr_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic [oqkr_pkg::STATUS_W-1:0] o_status,
    input logic [oqkr_pkg::OUT_W-1:0]    o_out_value,
    input logic [CW-1:0]                 o_entry_count
);
    import oqkr_pkg::*;

    // A result is only presented once the sequencer has gone idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && busy)) else $error("result strobe while busy");

    // An accepted transaction either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy)) else $error("transaction lost");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= CW'(DEPTH)) else $error("entry count above depth");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |-> (o_entry_count == '0 && o_out_value == '0))
        else $error("bad empty result");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_entry_count == CW'(DEPTH)
        && o_out_value == '0)) else $error("bad full result");

endmodule

bind ordered_queue_with_keyed_remove_core oqkr_checker #(
    .DEPTH(DEPTH),
    .CW   (CW)
) u_oqkr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_out_value  (o_out_value),
    .o_entry_count(o_entry_count)
);
